// ===== rtl/core/wmuc_pkg.sv =====
// shared types and constants of the wheel momentum unloading controller
`timescale 1ns / 1ps
package wmuc_pkg;

	localparam int NUM_WHEELS  = 4;
	localparam int IDX_W       = 2;
	localparam int MODE_DEPTH  = 2 ** IDX_W;
	localparam int SPEED_W     = 24;
	localparam int DIR_W       = 16;
	localparam int GAIN_W      = 32;
	localparam int ERR_W       = SPEED_W + 1;
	localparam int TORQUE_W    = 32;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_INC = 2'd1,
		MODE_DEC = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UPPER  = 3'd0,
		CFG_LOWER  = 3'd1,
		CFG_TARGET = 3'd2,
		CFG_GAIN   = 3'd3,
		CFG_ENABLE = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODE,
		ST_DIR_X,
		ST_DIR_Y,
		ST_DIR_Z,
		ST_ACC_Z,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0]          wheel_index;
		logic signed [SPEED_W-1:0] wheel_speed;
		logic signed [DIR_W-1:0]   dir_x;
		logic signed [DIR_W-1:0]   dir_y;
		logic signed [DIR_W-1:0]   dir_z;
		logic                      last_wheel;
	} in_word_t;

	typedef struct packed {
		logic [1:0]                 wheel_mode;
		logic [CNT_W-1:0]           active_count;
		logic signed [TORQUE_W-1:0] torque_x;
		logic signed [TORQUE_W-1:0] torque_y;
		logic signed [TORQUE_W-1:0] torque_z;
		logic                       frame_done;
		logic                       publish;
		logic                       mag_exclusive;
	} out_word_t;

	// sequencer to torque accumulator
	typedef struct packed {
		logic  gain_mul;
		logic  dir_mul;
		axis_t dir_axis;
		logic  acc;
		axis_t acc_axis;
		logic  clear;
	} acc_ctrl_t;

endpackage

// ===== rtl/core/wmuc_if.sv =====
// handshake channels of the wheel momentum unloading controller
`timescale 1ns / 1ps
interface wmuc_in_if import wmuc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wmuc_out_if import wmuc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wmuc_cfg_if import wmuc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/wheel_momentum_unloading_control.sv =====
// top level of the reaction wheel momentum unloading controller
`timescale 1ns / 1ps
//
//  channel   dir   word                                   handshake
//  samples   in    wheel index, speed, spin axis, last    valid/ready
//  results   out   mode, count, torque x/y/z, flags       valid/ready
//  cfg       in    register index, write data             valid/ready, ready always high
//
//  a sample is taken in the idle cycle, the mode memory is read at the accepting edge,
//  and after that edge the result is built in steps: mode update with the gain multiply,
//  three direction multiplies on one shared 45x16 multiplier with the accumulate of each
//  axis in the following cycle, then the result load; a new sample waits for idle
//  reset clears config registers, modes (through per-wheel valid bits), sums and count at once
//  a stalled result holds its register; the next sample is taken while it waits and
//  runs up to the load step, which waits for the result register to free up
//
module wheel_momentum_unloading_control import wmuc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	wmuc_in_if.sink    samples,
	wmuc_out_if.source results,
	wmuc_cfg_if.sink   cfg
);

	// configuration registers
	logic signed [SPEED_W-1:0] upper_q;
	logic signed [SPEED_W-1:0] lower_q;
	logic signed [SPEED_W-1:0] target_q;
	logic signed [GAIN_W-1:0]  gain_q;
	logic                      enable_q;

	// sequencer
	state_t state_q;
	state_t state_d;

	// current sample and derived values
	in_word_t                item_q;
	logic signed [ERR_W-1:0] err_q;
	logic                    active_q;
	mode_t                   mode_q;
	logic [CNT_W-1:0]        tally_q;

	// per-wheel mode memory, valid bits give the reset value of off
	mode_t                   mode_mem [MODE_DEPTH];
	mode_t                   mode_rd_q;
	logic [MODE_DEPTH-1:0]   mode_vld_q;
	mode_t                   mode_old;
	mode_t                   mode_new;
	logic                    idx_ok;

	// result register
	out_word_t out_q;
	logic      out_valid_q;
	logic      out_free;

	acc_ctrl_t                   acc_ctrl;
	logic signed [TORQUE_W-1:0]  torque_x;
	logic signed [TORQUE_W-1:0]  torque_y;
	logic signed [TORQUE_W-1:0]  torque_z;

	logic in_fire;
	logic emit;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;
	assign out_free      = !out_valid_q || results.ready;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= '0;
			lower_q  <= '0;
			target_q <= '0;
			gain_q   <= '0;
			enable_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_UPPER:  upper_q  <= cfg.wdata[SPEED_W-1:0];
				CFG_LOWER:  lower_q  <= cfg.wdata[SPEED_W-1:0];
				CFG_TARGET: target_q <= cfg.wdata[SPEED_W-1:0];
				CFG_GAIN:   gain_q   <= cfg.wdata[GAIN_W-1:0];
				CFG_ENABLE: enable_q <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// sample capture, speed error taken on acceptance
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= samples.data;
			err_q  <= ERR_W'(samples.data.wheel_speed) - ERR_W'(target_q);
		end
	end

	// mode memory: read on acceptance, written back in the mode step
	assign idx_ok = int'(item_q.wheel_index) < NUM_WHEELS;

	always_ff @(posedge clk) begin
		if (in_fire)
			mode_rd_q <= mode_mem[samples.data.wheel_index];
		if (state_q == ST_MODE && idx_ok)
			mode_mem[item_q.wheel_index] <= mode_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_vld_q <= '0;
		else if (state_q == ST_MODE && idx_ok)
			mode_vld_q[item_q.wheel_index] <= 1'b1;
	end

	// hysteresis of one wheel
	always_comb begin
		mode_old = mode_vld_q[item_q.wheel_index] ? mode_rd_q : MODE_OFF;
		mode_new = MODE_OFF;
		unique case (mode_old)
			MODE_OFF: begin
				if (item_q.wheel_speed > upper_q)
					mode_new = MODE_DEC;
				else if (item_q.wheel_speed < lower_q)
					mode_new = MODE_INC;
			end
			MODE_INC: mode_new = (item_q.wheel_speed >= target_q) ? MODE_OFF : MODE_INC;
			MODE_DEC: mode_new = (item_q.wheel_speed < target_q) ? MODE_OFF : MODE_DEC;
			default:  mode_new = MODE_OFF;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MODE) begin
			mode_q   <= idx_ok ? mode_new : MODE_OFF;
			active_q <= idx_ok && (mode_new != MODE_OFF);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d           = state_q;
		acc_ctrl          = '0;
		acc_ctrl.dir_axis = AXIS_X;
		acc_ctrl.acc_axis = AXIS_X;
		emit              = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_d = ST_MODE;
			end
			ST_MODE: begin
				acc_ctrl.gain_mul = 1'b1;
				state_d           = ST_DIR_X;
			end
			ST_DIR_X: begin
				acc_ctrl.dir_mul  = 1'b1;
				acc_ctrl.dir_axis = AXIS_X;
				state_d           = ST_DIR_Y;
			end
			ST_DIR_Y: begin
				acc_ctrl.dir_mul  = 1'b1;
				acc_ctrl.dir_axis = AXIS_Y;
				acc_ctrl.acc      = active_q;
				acc_ctrl.acc_axis = AXIS_X;
				state_d           = ST_DIR_Z;
			end
			ST_DIR_Z: begin
				acc_ctrl.dir_mul  = 1'b1;
				acc_ctrl.dir_axis = AXIS_Z;
				acc_ctrl.acc      = active_q;
				acc_ctrl.acc_axis = AXIS_Y;
				state_d           = ST_ACC_Z;
			end
			ST_ACC_Z: begin
				acc_ctrl.acc      = active_q;
				acc_ctrl.acc_axis = AXIS_Z;
				state_d           = ST_EMIT;
			end
			ST_EMIT: begin
				// load the result, then clear the period on the last wheel
				if (out_free) begin
					emit           = 1'b1;
					acc_ctrl.clear = item_q.last_wheel;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// active wheel count, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tally_q <= '0;
		else if (emit && item_q.last_wheel)
			tally_q <= '0;
		else if (state_q == ST_ACC_Z && active_q && tally_q != '1)
			tally_q <= tally_q + 1'b1;
	end

	wmuc_torque_acc u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (acc_ctrl),
		.err      (err_q),
		.gain     (gain_q),
		.dir_x    (item_q.dir_x),
		.dir_y    (item_q.dir_y),
		.dir_z    (item_q.dir_z),
		.torque_x (torque_x),
		.torque_y (torque_y),
		.torque_z (torque_z)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.wheel_mode    <= mode_q;
			out_q.active_count  <= tally_q;
			out_q.torque_x      <= torque_x;
			out_q.torque_y      <= torque_y;
			out_q.torque_z      <= torque_z;
			out_q.frame_done    <= item_q.last_wheel;
			out_q.publish       <= item_q.last_wheel && enable_q;
			out_q.mag_exclusive <= item_q.last_wheel && enable_q && (tally_q != '0);
		end
	end

endmodule

// ===== rtl/core/wmuc_torque_acc.sv =====
// shared multipliers and saturating 3-axis torque accumulator
`timescale 1ns / 1ps
module wmuc_torque_acc import wmuc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  acc_ctrl_t                  ctrl,
	input  logic signed [ERR_W-1:0]    err,
	input  logic signed [GAIN_W-1:0]   gain,
	input  logic signed [DIR_W-1:0]    dir_x,
	input  logic signed [DIR_W-1:0]    dir_y,
	input  logic signed [DIR_W-1:0]    dir_z,
	output logic signed [TORQUE_W-1:0] torque_x,
	output logic signed [TORQUE_W-1:0] torque_y,
	output logic signed [TORQUE_W-1:0] torque_z
);

	localparam int APROD_W = ERR_W + GAIN_W;     // 57
	localparam int A_W     = APROD_W - 12;       // 45, Q.24
	localparam int DPROD_W = A_W + DIR_W;        // 61
	localparam int C_W     = DPROD_W - 14;       // 47, Q.24
	localparam int SUM_W   = 48;

	logic signed [APROD_W-1:0] a_prod;
	logic signed [APROD_W-1:0] a_prod_q;
	logic signed [A_W-1:0]     a_val;
	logic signed [DIR_W-1:0]   dir_sel;
	logic signed [DPROD_W-1:0] d_prod;
	logic signed [DPROD_W-1:0] d_prod_q;
	logic signed [C_W-1:0]     c_val;
	logic signed [SUM_W-1:0]   sum_q [3];
	logic signed [SUM_W-1:0]   sum_sel;
	logic signed [SUM_W:0]     sum_wide;
	logic signed [SUM_W-1:0]   sum_next;

	function automatic logic signed [TORQUE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-TORQUE_W:0] top;
		top = v[SUM_W-1:TORQUE_W-1];
		if (top == '0 || top == '1)
			return v[TORQUE_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(TORQUE_W-1){1'b0}}};
		else
			return {1'b0, {(TORQUE_W-1){1'b1}}};
	endfunction

	// floor shifts are plain slices of the signed products
	assign a_prod = err * gain;
	assign a_val  = a_prod_q[APROD_W-1:12];
	assign d_prod = a_val * dir_sel;
	assign c_val  = d_prod_q[DPROD_W-1:14];

	always_comb begin
		unique case (ctrl.dir_axis)
			AXIS_X:  dir_sel = dir_x;
			AXIS_Y:  dir_sel = dir_y;
			AXIS_Z:  dir_sel = dir_z;
			default: dir_sel = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.acc_axis)
			AXIS_X:  sum_sel = sum_q[0];
			AXIS_Y:  sum_sel = sum_q[1];
			AXIS_Z:  sum_sel = sum_q[2];
			default: sum_sel = '0;
		endcase
		sum_wide = {sum_sel[SUM_W-1], sum_sel} + {{(SUM_W+1-C_W){c_val[C_W-1]}}, c_val};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
			                           : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_next = sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.gain_mul)
			a_prod_q <= a_prod;
		if (ctrl.dir_mul)
			d_prod_q <= d_prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				sum_q[k] <= '0;
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (ctrl.clear)
					sum_q[k] <= '0;
				else if (ctrl.acc && ctrl.acc_axis == axis_t'(2'(k)))
					sum_q[k] <= sum_next;
			end
		end
	end

	assign torque_x = sat32(sum_q[0]);
	assign torque_y = sat32(sum_q[1]);
	assign torque_z = sat32(sum_q[2]);

endmodule
